FILE: hdl/tdc_pkg.sv
package tdc_pkg;

	localparam int MAX_RANKS = 16;
	localparam int RANK_LIMIT = (MAX_RANKS < 16) ? MAX_RANKS : 16;
	localparam int RW = (RANK_LIMIT > 1) ? $clog2(RANK_LIMIT) : 1;
	localparam int CW = $clog2(RANK_LIMIT + 1);
	localparam int SUM_W = 36;
	localparam logic [4:0] RANK_COUNT_RESET = 5'd16;
	localparam logic [2:0] ADDR_RANK_COUNT = 3'd0;

	localparam logic [1:0] OP_REPORT = 2'd0;
	localparam logic [1:0] OP_CONFIRM = 2'd1;
	localparam logic [1:0] OP_TEST = 2'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_SHUTDOWN = 2'd1;
	localparam logic [1:0] KIND_REQUEST = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] source_rank;
		logic src_ok;
		logic [31:0] queued_count;
		logic [31:0] processed_count;
		logic [31:0] tag_value;
		logic [31:0] peer_internal_sent;
		logic [31:0] raw_queued_total;
		logic [31:0] raw_processed_total;
	} item_t;

	typedef struct packed {
		logic avail;
		item_t item;
	} head_t;

endpackage

FILE: hdl/tdc_if.sv
interface tdc_in_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [3:0] source_rank;
	logic [31:0] queued_count;
	logic [31:0] processed_count;
	logic [31:0] tag_value;
	logic [31:0] peer_internal_sent;
	logic [31:0] raw_queued_total;
	logic [31:0] raw_processed_total;
	modport source (output valid, opcode, source_rank, queued_count, processed_count,
		tag_value, peer_internal_sent, raw_queued_total, raw_processed_total, input ready);
	modport sink (input valid, opcode, source_rank, queued_count, processed_count,
		tag_value, peer_internal_sent, raw_queued_total, raw_processed_total, output ready);
endinterface

interface tdc_out_if;
	logic valid;
	logic ready;
	logic [1:0] msg_kind;
	logic [3:0] dest_rank;
	logic [31:0] count_a;
	logic [31:0] count_b;
	logic [31:0] out_tag;
	logic done_res;
	logic drained;
	logic last;
	modport source (output valid, msg_kind, dest_rank, count_a, count_b, out_tag,
		done_res, drained, last, input ready);
	modport sink (input valid, msg_kind, dest_rank, count_a, count_b, out_tag,
		done_res, drained, last, output ready);
endinterface

FILE: hdl/termination_detect_coordinator_core.sv
// the back engine takes a request in IDLE, updates the tables (UPD), sweeps the
// n active ranks (SWP), decides (DEC) and loads a registered result; a round of
// n-1 request or shutdown messages (n > 1) goes out one per cycle when ready, else
// one status message; the next request is taken only after the last one is loaded
// a two-entry request queue lets the front accept while the back works
// reset (arst_n, async): all counts unknown, tag and counters zero, rank_count 16
module termination_detect_coordinator_core import tdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	tdc_in_if.sink in_ch,
	tdc_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [4:0] rank_count_q;
	logic [CW-1:0] rank_n;
	head_t head;
	logic pop;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_RANK_COUNT) ? {27'd0, rank_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_count_q <= RANK_COUNT_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_RANK_COUNT) begin
			rank_count_q <= pwdata[4:0];
		end
	end

	// zero acts as one, above the table depth clamps
	always_comb begin
		if (rank_count_q == 5'd0) begin
			rank_n = CW'(1);
		end else if (6'(rank_count_q) > 6'(RANK_LIMIT)) begin
			rank_n = CW'(RANK_LIMIT);
		end else begin
			rank_n = CW'(rank_count_q);
		end
	end

	tdc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.rank_n(rank_n),
		.pop(pop),
		.head(head)
	);

	tdc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.rank_n(rank_n),
		.out_ch(out_ch)
	);

endmodule

FILE: hdl/tdc_front.sv
module tdc_front import tdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	tdc_in_if.sink in_ch,
	input logic [CW-1:0] rank_n,
	input logic pop,
	output head_t head
);

	item_t q_mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	item_t cls;

	// classify: does the source lie among the active ranks
	always_comb begin
		cls.opcode = in_ch.opcode;
		cls.source_rank = in_ch.source_rank;
		cls.src_ok = ({1'b0, in_ch.source_rank} < 5'(rank_n));
		cls.queued_count = in_ch.queued_count;
		cls.processed_count = in_ch.processed_count;
		cls.tag_value = in_ch.tag_value;
		cls.peer_internal_sent = in_ch.peer_internal_sent;
		cls.raw_queued_total = in_ch.raw_queued_total;
		cls.raw_processed_total = in_ch.raw_processed_total;
	end

	assign in_ch.ready = (count_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign head.avail = (count_q != 2'd0);
	assign head.item = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: hdl/tdc_back.sv
module tdc_back import tdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input head_t head,
	output logic pop,
	input logic [CW-1:0] rank_n,
	tdc_out_if.source out_ch
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD = 3'd1;
	localparam logic [2:0] ST_SWP = 3'd2;
	localparam logic [2:0] ST_DEC = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_STAT = 3'd5;

	logic [2:0] state_q;
	logic [RW-1:0] r_q;
	item_t cur_q;

	logic [RANK_LIMIT-1:0] qv_q, pv_q, tv_q, iv_q;
	logic [31:0] qd_q [RANK_LIMIT];
	logic [31:0] pd_q [RANK_LIMIT];
	logic [31:0] td_q [RANK_LIMIT];
	logic [31:0] id_q [RANK_LIMIT];
	logic [31:0] sc_q [RANK_LIMIT];

	logic [31:0] tag_q;
	logic lmv_q;
	logic [SUM_W-1:0] lm_q;
	logic [31:0] isent_q;
	logic [31:0] irecv_q;
	logic fin_q;
	logic shut_q;
	logic drained_q;

	logic [31:0] nq_q, np_q, q0_q, p0_q, i0_q;
	logic [SUM_W-1:0] qsum_q, psum_q, isum_q;
	logic tags_ok_q, known_q, ik_rest_q, ik0_q;

	logic o_valid_q;
	logic [1:0] o_kind_q;
	logic [3:0] o_dest_q;
	logic [31:0] o_a_q, o_b_q, o_tag_q;
	logic o_done_q, o_drained_q, o_last_q;

	logic [RW-1:0] addr;
	logic is_rep, is_conf, test_act, at_last, o_free, load_o;
	logic q_ev, p_ev;
	logic [31:0] q_e, p_e;
	logic req_go;
	logic [31:0] n_minus1;
	logic dr_norm, dr_req;

	assign addr = (state_q == ST_UPD) ? RW'(cur_q.source_rank) : r_q;
	assign is_rep = (cur_q.opcode == OP_REPORT) && cur_q.src_ok;
	assign is_conf = (cur_q.opcode == OP_CONFIRM) && cur_q.src_ok;
	assign test_act = (cur_q.opcode == OP_TEST) && !fin_q;
	assign at_last = ((CW'(r_q) + CW'(1)) == rank_n);
	assign o_free = !o_valid_q || out_ch.ready;
	assign load_o = o_free && ((state_q == ST_EMIT) || (state_q == ST_STAT));
	assign pop = (state_q == ST_IDLE) && head.avail;
	assign n_minus1 = 32'(rank_n) - 32'd1;

	// own totals fold into entry 0 during the sweep
	always_comb begin
		if ((r_q == '0) && test_act) begin
			q_ev = 1'b1;
			p_ev = 1'b1;
			q_e = (qv_q[addr] && qd_q[addr] > nq_q) ? qd_q[addr] : nq_q;
			p_e = (pv_q[addr] && pd_q[addr] > np_q) ? pd_q[addr] : np_q;
		end else begin
			q_ev = qv_q[addr];
			p_ev = pv_q[addr];
			q_e = qd_q[addr];
			p_e = pd_q[addr];
		end
	end

	assign req_go = known_q && (qsum_q == psum_q) && (!lmv_q || lm_q != psum_q);
	assign dr_norm = ik_rest_q && ik0_q && ((isum_q + SUM_W'(i0_q)) == SUM_W'(irecv_q));
	assign dr_req = ik_rest_q && (isum_q == SUM_W'(irecv_q));

	// payload and table data, no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.item;
		end
		unique case (state_q)
			ST_UPD: begin
				if (is_rep) begin
					qd_q[addr] <= (qv_q[addr] && qd_q[addr] >= cur_q.queued_count) ?
						qd_q[addr] : cur_q.queued_count;
					pd_q[addr] <= (pv_q[addr] && pd_q[addr] >= cur_q.processed_count) ?
						pd_q[addr] : cur_q.processed_count;
				end
				if (is_conf) begin
					td_q[addr] <= (tv_q[addr] && td_q[addr] >= cur_q.tag_value) ?
						td_q[addr] : cur_q.tag_value;
					id_q[addr] <= (iv_q[addr] && id_q[addr] >= cur_q.peer_internal_sent) ?
						id_q[addr] : cur_q.peer_internal_sent;
				end
				// local user counts, saturated at zero
				nq_q <= (cur_q.raw_queued_total >= isent_q) ?
					cur_q.raw_queued_total - isent_q : 32'd0;
				np_q <= (cur_q.raw_processed_total >= irecv_q) ?
					cur_q.raw_processed_total - irecv_q : 32'd0;
				qsum_q <= '0;
				psum_q <= '0;
				isum_q <= '0;
				tags_ok_q <= 1'b1;
				known_q <= 1'b1;
				ik_rest_q <= 1'b1;
				ik0_q <= 1'b0;
				i0_q <= 32'd0;
			end
			ST_SWP: begin
				tags_ok_q <= tags_ok_q && tv_q[addr] && (td_q[addr] == tag_q);
				known_q <= known_q && q_ev && p_ev;
				qsum_q <= qsum_q + SUM_W'(q_e);
				psum_q <= psum_q + SUM_W'(p_e);
				if (r_q == '0) begin
					q0_q <= q_e;
					p0_q <= p_e;
					ik0_q <= iv_q[addr];
					i0_q <= id_q[addr];
				end else begin
					ik_rest_q <= ik_rest_q && iv_q[addr];
					isum_q <= isum_q + SUM_W'(id_q[addr]);
				end
			end
			ST_DEC: begin
				drained_q <= (test_act && !tags_ok_q && req_go) ? dr_req : dr_norm;
				if (test_act && !tags_ok_q) begin
					qd_q[0] <= q0_q;
					pd_q[0] <= p0_q;
					if (req_go) begin
						td_q[0] <= tag_q + 32'd1;
						id_q[0] <= 32'd0;
						lm_q <= psum_q;
					end
				end
			end
			default: begin
			end
		endcase
		if (load_o) begin
			o_dest_q <= (state_q == ST_EMIT) ? 4'(r_q) : 4'd0;
			o_tag_q <= tag_q;
			o_done_q <= fin_q;
			o_drained_q <= drained_q;
			if (state_q == ST_STAT) begin
				o_kind_q <= KIND_STATUS;
				o_a_q <= 32'd0;
				o_b_q <= 32'd0;
				o_last_q <= 1'b1;
			end else begin
				o_kind_q <= shut_q ? KIND_SHUTDOWN : KIND_REQUEST;
				o_a_q <= shut_q ? sc_q[r_q] + 32'd1 : qd_q[r_q];
				o_b_q <= shut_q ? 32'd0 : pd_q[r_q];
				o_last_q <= at_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q <= '0;
			qv_q <= '0;
			pv_q <= '0;
			tv_q <= '0;
			iv_q <= '0;
			for (int i = 0; i < RANK_LIMIT; i++) begin
				sc_q[i] <= 32'd0;
			end
			tag_q <= 32'd0;
			lmv_q <= 1'b0;
			isent_q <= 32'd0;
			irecv_q <= 32'd0;
			fin_q <= 1'b0;
			shut_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			o_valid_q <= load_o || (o_valid_q && !out_ch.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (head.avail) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (is_rep) begin
						qv_q[addr] <= 1'b1;
						pv_q[addr] <= 1'b1;
					end
					if (is_conf) begin
						tv_q[addr] <= 1'b1;
						iv_q[addr] <= 1'b1;
					end
					if (is_rep || is_conf) begin
						irecv_q <= irecv_q + 32'd1;
					end
					r_q <= '0;
					state_q <= ST_SWP;
				end
				ST_SWP: begin
					if (at_last) begin
						state_q <= ST_DEC;
					end else begin
						r_q <= r_q + RW'(1);
					end
				end
				ST_DEC: begin
					r_q <= RW'(1);
					if (test_act && tags_ok_q) begin
						fin_q <= 1'b1;
						isent_q <= isent_q + n_minus1;
						shut_q <= 1'b1;
						state_q <= (rank_n != CW'(1)) ? ST_EMIT : ST_STAT;
					end else if (test_act) begin
						qv_q[0] <= 1'b1;
						pv_q[0] <= 1'b1;
						if (req_go) begin
							tag_q <= tag_q + 32'd1;
							tv_q[0] <= 1'b1;
							iv_q[0] <= 1'b1;
							lmv_q <= 1'b1;
							isent_q <= isent_q + n_minus1;
							shut_q <= 1'b0;
							state_q <= (rank_n != CW'(1)) ? ST_EMIT : ST_STAT;
						end else begin
							state_q <= ST_STAT;
						end
					end else begin
						state_q <= ST_STAT;
					end
				end
				ST_EMIT: begin
					if (o_free) begin
						sc_q[r_q] <= sc_q[r_q] + 32'd1;
						if (at_last) begin
							state_q <= ST_IDLE;
						end else begin
							r_q <= r_q + RW'(1);
						end
					end
				end
				ST_STAT: begin
					if (o_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid = o_valid_q;
	assign out_ch.msg_kind = o_kind_q;
	assign out_ch.dest_rank = o_dest_q;
	assign out_ch.count_a = o_a_q;
	assign out_ch.count_b = o_b_q;
	assign out_ch.out_tag = o_tag_q;
	assign out_ch.done_res = o_done_q;
	assign out_ch.drained = o_drained_q;
	assign out_ch.last = o_last_q;

endmodule

FILE: tb/sv/tb_termination_detect_coordinator_core.sv
module tb_termination_detect_coordinator_core;
	import tdc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] source_rank;
		logic [31:0] queued_count;
		logic [31:0] processed_count;
		logic [31:0] tag_value;
		logic [31:0] peer_internal_sent;
		logic [31:0] raw_queued_total;
		logic [31:0] raw_processed_total;
	} request_t;

	typedef struct packed {
		logic [1:0] msg_kind;
		logic [3:0] dest_rank;
		logic [31:0] count_a;
		logic [31:0] count_b;
		logic [31:0] out_tag;
		logic done_res;
		logic drained;
		logic last;
	} message_t;

	typedef struct {
		request_t req;
		bit typed;
		message_t msg;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tdc_in_if in_ch();
	tdc_out_if out_ch();

	termination_detect_coordinator_core u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the coordinator state
	longint q_max[16], p_max[16], tag_max[16], isent_max[16];
	logic [31:0] sent_cnt[16];
	logic [31:0] tag_now, isent, irecv;
	longint matched_sum;
	bit finished;
	logic [4:0] rank_reg;

	message_t pending_msgs[$];
	int errors = 0;
	int n_items = 0;
	bit quiet = 1'b0;
	bit hold_ask = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	int cycles = 0;

	function automatic int live_ranks();
		int n;
		n = rank_reg;
		if (n < 1) n = 1;
		if (n > RANK_LIMIT) n = RANK_LIMIT;
		return n;
	endfunction

	function automatic bit is_drained();
		longint s;
		s = 0;
		for (int r = 0; r < live_ranks(); r++) begin
			if (isent_max[r] < 0) return 1'b0;
			s += isent_max[r];
		end
		return s == longint'(irecv);
	endfunction

	function automatic bit all_tags_in();
		for (int r = 0; r < live_ranks(); r++)
			if (tag_max[r] != longint'(tag_now)) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void emit(ref message_t q[$], input logic [1:0] kind,
			input int dest, input longint a, input longint b, input bit lst);
		message_t m;
		m.msg_kind = kind;
		m.dest_rank = dest[3:0];
		m.count_a = a[31:0];
		m.count_b = b[31:0];
		m.out_tag = tag_now;
		m.done_res = finished;
		m.drained = is_drained();
		m.last = lst;
		q.push_back(m);
	endfunction

	function automatic longint user_count(logic [31:0] raw, logic [31:0] internal);
		return (raw >= internal) ? longint'(raw - internal) : 0;
	endfunction

	function automatic void coordinate(input request_t it, ref message_t q[$]);
		int n, k;
		longint nq, np, qs, ps;
		bit known;
		n = live_ranks();
		k = 0;
		if (it.opcode == OP_REPORT || it.opcode == OP_CONFIRM) begin
			if (it.source_rank < n) begin
				if (it.opcode == OP_REPORT) begin
					if (longint'(it.queued_count) > q_max[it.source_rank])
						q_max[it.source_rank] = it.queued_count;
					if (longint'(it.processed_count) > p_max[it.source_rank])
						p_max[it.source_rank] = it.processed_count;
				end else begin
					if (longint'(it.tag_value) > tag_max[it.source_rank])
						tag_max[it.source_rank] = it.tag_value;
					if (longint'(it.peer_internal_sent) > isent_max[it.source_rank])
						isent_max[it.source_rank] = it.peer_internal_sent;
				end
				irecv = irecv + 32'd1;
			end
		end else if (it.opcode == OP_TEST && !finished) begin
			if (all_tags_in()) begin
				finished = 1'b1;
				for (int r = 1; r < n; r++) begin
					isent = isent + 32'd1;
					sent_cnt[r] = sent_cnt[r] + 32'd1;
				end
				for (int r = 1; r < n; r++, k++)
					emit(q, KIND_SHUTDOWN, r, sent_cnt[r], 0, r + 1 == n);
			end else begin
				nq = user_count(it.raw_queued_total, isent);
				np = user_count(it.raw_processed_total, irecv);
				if (nq > q_max[0]) q_max[0] = nq;
				if (np > p_max[0]) p_max[0] = np;
				known = 1'b1;
				qs = 0;
				ps = 0;
				for (int r = 0; r < n; r++) begin
					if (q_max[r] < 0 || p_max[r] < 0) known = 1'b0;
					qs += q_max[r];
					ps += p_max[r];
				end
				if (known && qs == ps && ps != matched_sum) begin
					tag_now = tag_now + 32'd1;
					for (int r = 1; r < n; r++) begin
						isent = isent + 32'd1;
						sent_cnt[r] = sent_cnt[r] + 32'd1;
					end
					tag_max[0] = tag_now;
					isent_max[0] = 0;
					matched_sum = ps;
					for (int r = 1; r < n; r++, k++)
						emit(q, KIND_REQUEST, r, q_max[r], p_max[r], r + 1 == n);
				end
			end
		end
		if (k == 0) emit(q, KIND_STATUS, 0, 0, 0, 1'b1);
	endfunction

	task automatic send_request(input request_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= it.opcode;
		in_ch.source_rank <= it.source_rank;
		in_ch.queued_count <= it.queued_count;
		in_ch.processed_count <= it.processed_count;
		in_ch.tag_value <= it.tag_value;
		in_ch.peer_internal_sent <= it.peer_internal_sent;
		in_ch.raw_queued_total <= it.raw_queued_total;
		in_ch.raw_processed_total <= it.raw_processed_total;
		do @(posedge clk); while (!in_ch.ready);
		n_items++;
	endtask

	task automatic predict_and_send(input request_t it);
		coordinate(it, pending_msgs);
		send_request(it);
	endtask

	task automatic idle_channel();
		in_ch.valid <= 1'b0;
		while (pending_msgs.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_rank_count(input logic [4:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_RANK_COUNT;
		pwdata <= {27'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[4:0] !== val) begin
			errors++;
			if (errors <= 10) $display("rank_count read back %0d, wrote %0d", prdata[4:0], val);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		rank_reg = val;
	endtask

	function automatic request_t blank();
		request_t it;
		it = '0;
		it.queued_count = $urandom;
		it.processed_count = $urandom;
		it.tag_value = $urandom;
		it.peer_internal_sent = $urandom;
		it.raw_queued_total = $urandom;
		it.raw_processed_total = $urandom;
		return it;
	endfunction

	task automatic random_round(input bit last_phase);
		int n;
		request_t it;
		longint qs, ps, x, s;
		bit known;
		n = live_ranks();
		for (int r = 1; r < n; r++) begin
			if ($urandom_range(0, 9) < 8) begin
				it = blank();
				it.opcode = OP_REPORT;
				it.source_rank = 4'(r);
				it.queued_count = 32'((q_max[r] < 0 || $urandom_range(0, 4) == 0) ?
					longint'($urandom_range(0, 100)) : q_max[r] + $urandom_range(0, 20));
				it.processed_count = 32'((p_max[r] < 0 || $urandom_range(0, 4) == 0) ?
					longint'($urandom_range(0, 100)) : p_max[r] + $urandom_range(0, 20));
				predict_and_send(it);
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			it = blank();
			it.opcode = ($urandom_range(0, 1) != 0) ? OP_UNUSED : OP_REPORT;
			it.source_rank = 4'($urandom_range(n < 16 ? n : 0, 15));
			if (n == 16) it.opcode = OP_UNUSED;
			predict_and_send(it);
		end
		// completion test, usually with totals that balance the sums
		it = blank();
		it.opcode = OP_TEST;
		it.raw_queued_total = 32'($urandom_range(0, 200));
		it.raw_processed_total = 32'($urandom_range(0, 200));
		known = 1'b1;
		qs = 0;
		ps = 0;
		for (int r = 1; r < n; r++) begin
			if (q_max[r] < 0 || p_max[r] < 0) known = 1'b0;
			qs += q_max[r];
			ps += p_max[r];
		end
		if (known && $urandom_range(0, 9) < 7) begin
			x = (q_max[0] > p_max[0] ? q_max[0] : p_max[0]) + $urandom_range(1, 40);
			if (x < 0) x = $urandom_range(1, 40);
			it.raw_queued_total = 32'((qs >= ps ? x : x + ps - qs) + isent);
			it.raw_processed_total = 32'((qs >= ps ? x + qs - ps : x) + irecv);
		end
		if (!last_phase && !finished && all_tags_in()) begin
			// hold off shutdown until the last phase
			it.opcode = OP_CONFIRM;
			it.source_rank = 4'd0;
			it.tag_value = tag_now + 32'd1;
			it.peer_internal_sent = 32'($urandom_range(0, 50));
		end
		predict_and_send(it);
		for (int r = 1; r < n; r++) begin
			it = blank();
			it.opcode = OP_CONFIRM;
			it.source_rank = 4'(r);
			it.tag_value = ($urandom_range(0, 9) == 0) ? tag_now - 32'd1 : tag_now;
			it.peer_internal_sent = 32'($urandom_range(0, 30));
			if (r == n - 1 && $urandom_range(0, 2) == 0) begin
				// try to make internal traffic balance
				s = 0;
				for (int j = 0; j < n; j++)
					if (j != r) s += (isent_max[j] < 0) ? 0 : isent_max[j];
				x = longint'(irecv) + 1 - s;
				if (x >= 0 && x < 64'h1_0000_0000) it.peer_internal_sent = x[31:0];
			end
			predict_and_send(it);
		end
		if (last_phase) begin
			it = blank();
			it.opcode = OP_TEST;
			it.raw_queued_total = 32'($urandom_range(0, 200));
			it.raw_processed_total = 32'($urandom_range(0, 200));
			predict_and_send(it);
		end
	endtask

	// result side: random stalls, one long hold-off on request
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL termination_detect_coordinator_core");
			$finish;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_msgs.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", out_ch.msg_kind);
			end else begin
				message_t e;
				e = pending_msgs.pop_front();
				if (e.msg_kind !== out_ch.msg_kind || e.dest_rank !== out_ch.dest_rank ||
						e.count_a !== out_ch.count_a || e.count_b !== out_ch.count_b ||
						e.out_tag !== out_ch.out_tag || e.done_res !== out_ch.done_res ||
						e.drained !== out_ch.drained || e.last !== out_ch.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp kind %0d dest %0d a %0h b %0h tag %0h done %0b dr %0b last %0b / got kind %0d dest %0d a %0h b %0h tag %0h done %0b dr %0b last %0b",
							e.msg_kind, e.dest_rank, e.count_a, e.count_b, e.out_tag,
							e.done_res, e.drained, e.last, out_ch.msg_kind, out_ch.dest_rank,
							out_ch.count_a, out_ch.count_b, out_ch.out_tag, out_ch.done_res,
							out_ch.drained, out_ch.last);
				end
			end
		end
		if (hold_ask && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = int'($urandom_range(0, 3));
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	table_row_t rows[$];
	logic [4:0] phase_ranks[6] = '{5'd3, 5'd0, 5'd31, 5'd7, 5'd1, 5'd2};

	initial begin
		table_row_t row;
		request_t it;
		message_t scratch[$];
		int start;

		in_ch.valid = 1'b0;
		in_ch.opcode = '0;
		in_ch.source_rank = '0;
		in_ch.queued_count = '0;
		in_ch.processed_count = '0;
		in_ch.tag_value = '0;
		in_ch.peer_internal_sent = '0;
		in_ch.raw_queued_total = '0;
		in_ch.raw_processed_total = '0;

		for (int r = 0; r < 16; r++) begin
			q_max[r] = -1;
			p_max[r] = -1;
			tag_max[r] = -1;
			isent_max[r] = -1;
			sent_cnt[r] = '0;
		end
		tag_now = '0;
		isent = '0;
		irecv = '0;
		matched_sum = -1;
		finished = 1'b0;
		rank_reg = RANK_COUNT_RESET;

		// directed part at the reset rank count
		row = '{default: '0};
		row.typed = 1'b1;
		row.msg = '{KIND_STATUS, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1};
		row.req = '0;
		row.req.opcode = OP_REPORT;
		row.req.source_rank = 4'd15;
		row.req.queued_count = '1;
		rows.push_back(row);
		row.req.queued_count = '0;
		row.req.processed_count = '1;
		rows.push_back(row);
		row.req = '0;
		row.req.opcode = OP_CONFIRM;
		row.req.source_rank = 4'd15;
		row.req.tag_value = '1;
		row.req.peer_internal_sent = '1;
		rows.push_back(row);
		row.req = '1;
		row.req.opcode = OP_UNUSED;
		rows.push_back(row);
		// counts still unknown on most ranks
		row.req = '0;
		row.req.opcode = OP_TEST;
		rows.push_back(row);
		row.typed = 1'b0;
		for (int r = 1; r < 15; r++) begin
			row.req = '0;
			row.req.opcode = OP_REPORT;
			row.req.source_rank = 4'(r);
			row.req.queued_count = 32'(r);
			row.req.processed_count = 32'(r);
			rows.push_back(row);
		end
		row.req = '0;
		row.req.opcode = OP_TEST;
		rows.push_back(row);
		rows.push_back(row);
		row.req = '0;
		row.req.opcode = OP_CONFIRM;
		row.req.source_rank = 4'd0;
		row.req.tag_value = 32'd1;
		rows.push_back(row);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				scratch.delete();
				coordinate(rows[i].req, scratch);
				pending_msgs.push_back(rows[i].msg);
				send_request(rows[i].req);
			end else begin
				predict_and_send(rows[i].req);
			end
		end
		idle_channel();

		foreach (phase_ranks[ph]) begin
			write_rank_count(phase_ranks[ph]);
			if (ph == 2) hold_ask = 1'b1;
			if (ph == 5) quiet = 1'b1;
			start = n_items;
			if (ph == 5) begin
				while (!finished && n_items - start < 60) random_round(1'b1);
				// tests and traffic once finished, raw totals all ones, then all zeros
				it = '1;
				it.opcode = OP_TEST;
				predict_and_send(it);
				it.raw_queued_total = '0;
				it.raw_processed_total = '0;
				predict_and_send(it);
				random_round(1'b1);
			end else begin
				while (n_items - start < 40) random_round(1'b0);
			end
			idle_channel();
		end

		if (errors == 0 && pending_msgs.size() == 0)
			$display("PASS termination_detect_coordinator_core");
		else
			$display("FAIL termination_detect_coordinator_core");
		$finish;
	end

endmodule
